### sv/sha1_pkg.sv
// ============================================================================
// SHA-1 shared definitions
// Transfer types, queue sizing and hash constants for the SHA-1 digest unit.
// ============================================================================
package sha1_pkg;

    // One message item: a byte and its two flags.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       end_of_message;
    } in_item_t;

    // One digest word as it leaves the block.
    typedef struct packed {
        logic [31:0] digest_word;
        logic        digest_last;
    } out_item_t;

    // One 32-bit schedule word passed from the byte packer to the compressor.
    // The last flag marks the final word of a padded message.
    typedef struct packed {
        logic [31:0] word;
        logic        last;
    } q_entry_t;

    // Word queue between the packer and the compressor: one whole block.
    localparam int QUEUE_DEPTH = 16;
    localparam int QUEUE_AW    = 4;

    // Padding marker byte and the word slot where the bit length starts.
    localparam logic [7:0] PAD_BYTE      = 8'h80;
    localparam logic [3:0] LEN_WORD_SLOT = 4'd14;

    // Number of words in one block, minus one.
    localparam logic [3:0] BLOCK_LAST_WORD = 4'd15;

    // Round constants.
    localparam logic [31:0] K_0 = 32'h5A827999;
    localparam logic [31:0] K_1 = 32'h6ED9EBA1;
    localparam logic [31:0] K_2 = 32'h8F1BBCDC;
    localparam logic [31:0] K_3 = 32'hCA62C1D6;

    // Initial hash values.
    localparam logic [31:0] H_INIT [5] = '{
        32'h67452301,
        32'hEFCDAB89,
        32'h98BADCFE,
        32'h10325476,
        32'hC3D2E1F0
    };

endpackage

### sv/sha1_front.sv
// ============================================================================
// SHA-1 byte packer
// Accepts message bytes, packs them big-endian into words, counts the bit
// length and, at the end of a message, generates the padding words.
// ============================================================================
module sha1_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_ready,
    input  sha1_pkg::in_item_t  item,
    output logic                push_valid,
    output sha1_pkg::q_entry_t  push_entry,
    input  logic                q_full
);

    typedef enum logic [2:0] {
        F_IDLE,
        F_PAD,
        F_ZERO,
        F_LENH,
        F_LENL
    } state_t;

    state_t      state_reg, state_next;
    logic [23:0] partial_reg, partial_next;
    logic [1:0]  byte_cnt_reg, byte_cnt_next;
    logic [3:0]  word_idx_reg, word_idx_next;
    logic [63:0] bit_len_reg, bit_len_next;

    logic        accept;
    logic [4:0]  pad_shift;
    logic [31:0] pad_word;

    // New items are taken only between padding sequences and with queue room.
    assign item_ready = (state_reg == F_IDLE) && !q_full;
    assign accept     = item_valid && item_ready;

    // The pad word holds the leftover bytes, the marker byte, then zeros.
    assign pad_shift = {2'd3 - byte_cnt_reg, 3'b000};
    assign pad_word  = {partial_reg, sha1_pkg::PAD_BYTE} << pad_shift;

    // Next-state and word push logic.
    always_comb
    begin
        state_next      = state_reg;
        partial_next    = partial_reg;
        byte_cnt_next   = byte_cnt_reg;
        word_idx_next   = word_idx_reg;
        bit_len_next    = bit_len_reg;
        push_valid      = 1'b0;
        push_entry.word = '0;
        push_entry.last = 1'b0;

        case (state_reg)
            F_IDLE:
            begin
                if (accept)
                begin
                    if (item.byte_present)
                    begin
                        bit_len_next = bit_len_reg + 64'd8;
                        if (byte_cnt_reg == 2'd3)
                        begin
                            push_valid      = 1'b1;
                            push_entry.word = {partial_reg, item.data_byte};
                            partial_next    = '0;
                            byte_cnt_next   = 2'd0;
                            word_idx_next   = word_idx_reg + 4'd1;
                        end
                        else
                        begin
                            partial_next  = {partial_reg[15:0], item.data_byte};
                            byte_cnt_next = byte_cnt_reg + 2'd1;
                        end
                    end
                    if (item.end_of_message)
                    begin
                        state_next = F_PAD;
                    end
                end
            end

            F_PAD:
            begin
                if (!q_full)
                begin
                    push_valid      = 1'b1;
                    push_entry.word = pad_word;
                    partial_next    = '0;
                    byte_cnt_next   = 2'd0;
                    word_idx_next   = word_idx_reg + 4'd1;
                    state_next      = F_ZERO;
                end
            end

            F_ZERO:
            begin
                if (word_idx_reg == sha1_pkg::LEN_WORD_SLOT)
                begin
                    state_next = F_LENH;
                end
                else if (!q_full)
                begin
                    push_valid    = 1'b1;
                    word_idx_next = word_idx_reg + 4'd1;
                end
            end

            F_LENH:
            begin
                if (!q_full)
                begin
                    push_valid      = 1'b1;
                    push_entry.word = bit_len_reg[63:32];
                    word_idx_next   = word_idx_reg + 4'd1;
                    state_next      = F_LENL;
                end
            end

            F_LENL:
            begin
                if (!q_full)
                begin
                    push_valid      = 1'b1;
                    push_entry.word = bit_len_reg[31:0];
                    push_entry.last = 1'b1;
                    word_idx_next   = word_idx_reg + 4'd1;
                    bit_len_next    = '0;
                    state_next      = F_IDLE;
                end
            end

            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    // State and counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= F_IDLE;
            partial_reg  <= '0;
            byte_cnt_reg <= '0;
            word_idx_reg <= '0;
            bit_len_reg  <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            partial_reg  <= partial_next;
            byte_cnt_reg <= byte_cnt_next;
            word_idx_reg <= word_idx_next;
            bit_len_reg  <= bit_len_next;
        end
    end

`ifndef SYNTH
    // No item is taken while padding words are still being generated.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != F_IDLE) |-> !item_ready)
        else $error("front accepted an item during padding");

    // A word is offered to the queue only when it has room.
    assert property (@(posedge clk) disable iff (!rst_n)
        push_valid |-> !q_full)
        else $error("front pushed into a full queue");

    // The length word closes a block, so the next message starts clean.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == F_LENL && !q_full) |=>
            (word_idx_reg == 4'd0 && bit_len_reg == 64'd0 && byte_cnt_reg == 2'd0))
        else $error("front did not end the message on a block boundary");
`endif

endmodule

### sv/sha1_queue.sv
// ============================================================================
// SHA-1 word queue
// A one-block FIFO of schedule words between the byte packer and the
// compressor, so that packing continues while a block is being compressed.
// ============================================================================
module sha1_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push_valid,
    input  sha1_pkg::q_entry_t  push_entry,
    output logic                full,
    output logic                pop_valid,
    input  logic                pop_ready,
    output sha1_pkg::q_entry_t  pop_entry
);

    localparam int AW = sha1_pkg::QUEUE_AW;

    sha1_pkg::q_entry_t mem_reg [sha1_pkg::QUEUE_DEPTH];
    logic [AW-1:0]      wr_ptr_reg, rd_ptr_reg;
    logic [AW:0]        count_reg;
    logic               do_push, do_pop;

    // Status and transfer qualifiers.
    assign full      = (count_reg == (AW+1)'(sha1_pkg::QUEUE_DEPTH));
    assign pop_valid = (count_reg != '0);
    assign do_push   = push_valid && !full;
    assign do_pop    = pop_valid && pop_ready;
    assign pop_entry = mem_reg[rd_ptr_reg];

    // Storage write.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

`ifndef SYNTH
    // The fill count never passes the depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (AW+1)'(sha1_pkg::QUEUE_DEPTH))
        else $error("queue count out of range");

    // A push without a pop grows the count by exactly one.
    assert property (@(posedge clk) disable iff (!rst_n)
        (do_push && !do_pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count did not follow a push");

    // Write and read pointers stay a fill count apart.
    assert property (@(posedge clk) disable iff (!rst_n)
        (wr_ptr_reg - rd_ptr_reg) == count_reg[AW-1:0])
        else $error("queue pointers disagree with count");
`endif

endmodule

### sv/sha1_core.sv
// ============================================================================
// SHA-1 compressor
// Loads sixteen schedule words from the queue, runs the 80 rounds one per
// cycle with a rolling schedule window, chains the result and sends out the
// five digest words at the end of a message.
// ============================================================================
module sha1_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                pop_valid,
    output logic                pop_ready,
    input  sha1_pkg::q_entry_t  pop_entry,
    output logic                digest_valid,
    input  logic                digest_ready,
    output sha1_pkg::out_item_t digest
);

    typedef enum logic [1:0] {
        C_LOAD,
        C_ROUND,
        C_ADD,
        C_OUT
    } state_t;

    localparam logic [6:0] ROUND_LAST = 7'd79;
    localparam logic [2:0] OUT_LAST   = 3'd4;

    state_t      state_reg;
    logic [3:0]  load_cnt_reg;
    logic [6:0]  round_reg;
    logic        final_reg;
    logic [31:0] chain_reg [5];
    logic        out_valid_reg;
    logic [2:0]  out_idx_reg;
    logic [31:0] out_word_reg;

    logic [31:0] window_reg [16];
    logic [31:0] a_reg, b_reg, c_reg, d_reg, e_reg;

    logic        load_word;
    logic [31:0] f_val, k_val, temp, w_new, w_mix;

    assign pop_ready              = (state_reg == C_LOAD);
    assign load_word              = pop_valid && pop_ready;
    assign digest_valid           = out_valid_reg;
    assign digest.digest_word     = out_word_reg;
    assign digest.digest_last     = (out_idx_reg == OUT_LAST);

    // Round function and constant by round group.
    always_comb
    begin
        if (round_reg < 7'd20)
        begin
            f_val = (b_reg & c_reg) | (~b_reg & d_reg);
            k_val = sha1_pkg::K_0;
        end
        else if (round_reg < 7'd40)
        begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = sha1_pkg::K_1;
        end
        else if (round_reg < 7'd60)
        begin
            f_val = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg);
            k_val = sha1_pkg::K_2;
        end
        else
        begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = sha1_pkg::K_3;
        end
    end

    // Round sum and the next schedule word, W[t+16] from the rolling window.
    assign temp  = {a_reg[26:0], a_reg[31:27]} + f_val + e_reg + k_val + window_reg[0];
    assign w_mix = window_reg[13] ^ window_reg[8] ^ window_reg[2] ^ window_reg[0];
    assign w_new = {w_mix[30:0], w_mix[31]};

    // Schedule window and working variables.
    always_ff @(posedge clk)
    begin
        if (load_word)
        begin
            for (int i = 0; i < 15; i++)
            begin
                window_reg[i] <= window_reg[i+1];
            end
            window_reg[15] <= pop_entry.word;
            if (load_cnt_reg == sha1_pkg::BLOCK_LAST_WORD)
            begin
                a_reg <= chain_reg[0];
                b_reg <= chain_reg[1];
                c_reg <= chain_reg[2];
                d_reg <= chain_reg[3];
                e_reg <= chain_reg[4];
            end
        end
        else if (state_reg == C_ROUND)
        begin
            for (int i = 0; i < 15; i++)
            begin
                window_reg[i] <= window_reg[i+1];
            end
            window_reg[15] <= w_new;
            a_reg <= temp;
            b_reg <= a_reg;
            c_reg <= {b_reg[1:0], b_reg[31:2]};
            d_reg <= c_reg;
            e_reg <= d_reg;
        end
    end

    // Sequencer, chaining values and the digest output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= C_LOAD;
            load_cnt_reg  <= '0;
            round_reg     <= '0;
            final_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            out_idx_reg   <= '0;
            out_word_reg  <= '0;
            for (int i = 0; i < 5; i++)
            begin
                chain_reg[i] <= sha1_pkg::H_INIT[i];
            end
        end
        else
        begin
            case (state_reg)
                C_LOAD:
                begin
                    if (load_word)
                    begin
                        load_cnt_reg <= load_cnt_reg + 4'd1;
                        if (load_cnt_reg == sha1_pkg::BLOCK_LAST_WORD)
                        begin
                            final_reg <= pop_entry.last;
                            round_reg <= '0;
                            state_reg <= C_ROUND;
                        end
                    end
                end

                C_ROUND:
                begin
                    round_reg <= round_reg + 7'd1;
                    if (round_reg == ROUND_LAST)
                    begin
                        state_reg <= C_ADD;
                    end
                end

                C_ADD:
                begin
                    chain_reg[0] <= chain_reg[0] + a_reg;
                    chain_reg[1] <= chain_reg[1] + b_reg;
                    chain_reg[2] <= chain_reg[2] + c_reg;
                    chain_reg[3] <= chain_reg[3] + d_reg;
                    chain_reg[4] <= chain_reg[4] + e_reg;
                    if (final_reg)
                    begin
                        out_valid_reg <= 1'b1;
                        out_idx_reg   <= '0;
                        out_word_reg  <= chain_reg[0] + a_reg;
                        state_reg     <= C_OUT;
                    end
                    else
                    begin
                        state_reg <= C_LOAD;
                    end
                end

                C_OUT:
                begin
                    if (digest_ready)
                    begin
                        if (out_idx_reg == OUT_LAST)
                        begin
                            out_valid_reg <= 1'b0;
                            final_reg     <= 1'b0;
                            state_reg     <= C_LOAD;
                            for (int i = 0; i < 5; i++)
                            begin
                                chain_reg[i] <= sha1_pkg::H_INIT[i];
                            end
                        end
                        else
                        begin
                            out_idx_reg  <= out_idx_reg + 3'd1;
                            out_word_reg <= chain_reg[out_idx_reg + 3'd1];
                        end
                    end
                end

                default:
                begin
                    state_reg <= C_LOAD;
                end
            endcase
        end
    end

`ifndef SYNTH
    // The round counter stays within the 80 rounds.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == C_ROUND) |-> (round_reg <= ROUND_LAST))
        else $error("round counter out of range");

    // The sixteenth word of a block starts the rounds at round zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (load_word && load_cnt_reg == sha1_pkg::BLOCK_LAST_WORD) |=>
            (state_reg == C_ROUND && round_reg == 7'd0))
        else $error("block load did not start the rounds");

    // After the last digest word the chain is back at its initial value.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == C_OUT && digest_ready && out_idx_reg == OUT_LAST) |=>
            (state_reg == C_LOAD && chain_reg[0] == sha1_pkg::H_INIT[0]
             && chain_reg[4] == sha1_pkg::H_INIT[4] && !digest_valid))
        else $error("chain not restarted after digest");
`endif

endmodule

### sv/sha1_message_digest_unit.sv
// ============================================================================
// SHA-1 message digest unit
// Streaming SHA-1 engine taking one message byte per transfer and returning
// the five digest words of each message.
// ============================================================================
// A message arrives one byte per transfer; an end marker, with or without a
// final byte, closes it and may stand alone for an empty message. The packer
// takes one byte per cycle while the queue has room and it is not padding,
// and feeds a one-block word queue, so it keeps collecting the next block
// while the compressor works. The compressor loads a 64-byte block word by
// word from the queue, runs the rounds one per cycle and then chains the
// result, so a steady stream is paced by the round loop. The end of a
// message adds the padding words, while no byte is taken, one or two final
// blocks, and five digest transfers, highest word first, the fifth marked
// with digest_last. The engine then starts over from the initial hash value.
// ============================================================================
module sha1_message_digest_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_ready,
    input  sha1_pkg::in_item_t  item,
    output logic                digest_valid,
    input  logic                digest_ready,
    output sha1_pkg::out_item_t digest
);

    logic               push_valid;
    sha1_pkg::q_entry_t push_entry;
    logic               q_full;
    logic               pop_valid;
    logic               pop_ready;
    sha1_pkg::q_entry_t pop_entry;

    // Byte packer and padding generator.
    sha1_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .push_valid (push_valid),
        .push_entry (push_entry),
        .q_full     (q_full)
    );

    // Word queue between packer and compressor.
    sha1_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_entry (push_entry),
        .full       (q_full),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_entry  (pop_entry)
    );

    // Compression rounds and digest output.
    sha1_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .pop_valid    (pop_valid),
        .pop_ready    (pop_ready),
        .pop_entry    (pop_entry),
        .digest_valid (digest_valid),
        .digest_ready (digest_ready),
        .digest       (digest)
    );

endmodule

### test/sha1_message_digest_unit_tb.sv
`timescale 1ns / 100ps
// ============================================================================
// SHA-1 message digest unit testbench
// Streams messages into the digest unit one byte per transfer and checks
// every returned digest word against a behavioral SHA-1 hash kept in the
// bench or a digest typed in by hand. A short table of directed messages
// comes first, then random messages in three handshake phases, with a long output stall.
// ============================================================================
module sha1_message_digest_unit_tb;

    localparam int HALF_PERIOD    = 5;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 300;
    localparam int LONG_HOLD      = 600;
    localparam int PHASE_ITEMS    = 110;
    localparam int PHASE_MESSAGES = 4;

    // One row of the directed table: the item, and the digest when it is
    // typed in by hand rather than taken from the bench hash.
    typedef struct packed {
        sha1_pkg::in_item_t stim;
        logic               typed;
        logic [159:0]       words;
    } dir_row_t;

    logic                clk          = 1'b0;
    logic                rst_n        = 1'b0;
    logic                item_valid   = 1'b0;
    logic                item_ready;
    sha1_pkg::in_item_t  msg_item     = '0;
    logic                digest_valid;
    logic                digest_ready = 1'b0;
    sha1_pkg::out_item_t digest_out;

    // Handshake shaping for the sender and the receiver processes, set by the main sequence.
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int hold_left   = 0;

    int error_count = 0;
    int idle_count  = 0;

    // Bench copy of the hash state.
    logic [31:0] hash_words [5];
    logic [31:0] sched_words [16];
    logic [5:0]  blk_fill;
    logic [23:0] word_bytes;
    logic [63:0] msg_bits;

    // Digest words still owed by the block, oldest first.
    sha1_pkg::out_item_t pending_digest_q [$];

    dir_row_t dir_rows [0:11];

    sha1_message_digest_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (msg_item),
        .digest_valid (digest_valid),
        .digest_ready (digest_ready),
        .digest       (digest_out)
    );

    // Free-running clock.
    always #HALF_PERIOD clk = ~clk;

    function automatic logic [31:0] rotl(input logic [31:0] v, input int s);
        return (v << s) | (v >> (32 - s));
    endfunction

    task automatic restart_hash();
        hash_words = sha1_pkg::H_INIT;
        blk_fill   = '0;
        word_bytes = '0;
        msg_bits   = '0;
    endtask

    // Eighty rounds over the current block, chained into the hash words.
    task automatic compress_block();
        logic [31:0] a, b, c, d, e, f, k, w, sum;
        int r;
        a = hash_words[0];
        b = hash_words[1];
        c = hash_words[2];
        d = hash_words[3];
        e = hash_words[4];
        for (r = 0; r < 80; r++)
        begin
            if (r < 16)
            begin
                w = sched_words[r];
            end
            else
            begin
                w = rotl(sched_words[(r - 3) % 16] ^ sched_words[(r - 8) % 16] ^
                         sched_words[(r - 14) % 16] ^ sched_words[r % 16], 1);
                sched_words[r % 16] = w;
            end
            if (r < 20)
            begin
                f = (b & c) | (~b & d);
                k = sha1_pkg::K_0;
            end
            else if (r < 40)
            begin
                f = b ^ c ^ d;
                k = sha1_pkg::K_1;
            end
            else if (r < 60)
            begin
                f = (b & c) | (b & d) | (c & d);
                k = sha1_pkg::K_2;
            end
            else
            begin
                f = b ^ c ^ d;
                k = sha1_pkg::K_3;
            end
            sum = rotl(a, 5) + f + e + k + w;
            e   = d;
            d   = c;
            c   = rotl(b, 30);
            b   = a;
            a   = sum;
        end
        hash_words[0] += a;
        hash_words[1] += b;
        hash_words[2] += c;
        hash_words[3] += d;
        hash_words[4] += e;
    endtask

    // Big-endian byte packing into schedule words; a full block compresses.
    task automatic absorb_byte(input logic [7:0] b);
        if (blk_fill[1:0] == 2'd3)
        begin
            sched_words[blk_fill[5:2]] = {word_bytes, b};
            word_bytes = '0;
        end
        else
        begin
            word_bytes = {word_bytes[15:0], b};
        end
        blk_fill = blk_fill + 6'd1;
        if (blk_fill == 6'd0)
        begin
            compress_block();
        end
    endtask

    // Fold one accepted item into the hash; on an end marker pad, finish
    // and hand back the digest.
    task automatic fold_item(input sha1_pkg::in_item_t it, output logic done,
                             output logic [159:0] words);
        logic [63:0] len;
        int i;
        done  = 1'b0;
        words = '0;
        if (it.byte_present)
        begin
            absorb_byte(it.data_byte);
            msg_bits = msg_bits + 64'd8;
        end
        if (it.end_of_message)
        begin
            len = msg_bits;
            absorb_byte(sha1_pkg::PAD_BYTE);
            while (blk_fill != 6'd56)
            begin
                absorb_byte(8'h00);
            end
            for (i = 0; i < 8; i++)
            begin
                absorb_byte(len[63 - 8 * i -: 8]);
            end
            words = {hash_words[0], hash_words[1], hash_words[2],
                     hash_words[3], hash_words[4]};
            done  = 1'b1;
            restart_hash();
        end
    endtask

    // Offer one item after a random idle gap and hold it until the transfer.
    task automatic send_item(input sha1_pkg::in_item_t it, input logic typed,
                             input logic [159:0] typed_words);
        logic                done;
        logic [159:0]        words;
        sha1_pkg::out_item_t owed;
        int                  i;
        @(negedge clk);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item_valid <= 1'b1;
        msg_item   <= it;
        do
        begin
            @(posedge clk);
        end
        while (item_ready !== 1'b1);
        fold_item(it, done, words);
        if (done)
        begin
            if (typed)
            begin
                words = typed_words;
            end
            for (i = 0; i < 5; i++)
            begin
                owed.digest_word = words[159 - 32 * i -: 32];
                owed.digest_last = (i == 4);
                pending_digest_q.push_back(owed);
            end
        end
    endtask

    // One random message: mostly short, some around the padding boundary, a few
    // near that boundary in a second block, with stray empty items mixed in.
    task automatic send_random_message(inout int sent);
        sha1_pkg::in_item_t it;
        int                 len;
        int                 sel;
        int                 i;
        logic               end_on_byte;
        sel = $urandom_range(99);
        if (sel < 65)
        begin
            len = $urandom_range(12);
        end
        else if (sel < 90)
        begin
            len = $urandom_range(68, 52);
        end
        else if (sel < 95)
        begin
            len = $urandom_range(130, 118);
        end
        else
        begin
            len = $urandom_range(2);
        end
        end_on_byte = (len > 0) && ($urandom_range(1) == 1);
        for (i = 0; i < len; i++)
        begin
            if ($urandom_range(19) == 0)
            begin
                it.data_byte      = 8'($urandom_range(255));
                it.byte_present   = 1'b0;
                it.end_of_message = 1'b0;
                send_item(it, 1'b0, '0);
            end
            it.data_byte      = 8'($urandom_range(255));
            it.byte_present   = 1'b1;
            it.end_of_message = end_on_byte && (i == len - 1);
            send_item(it, 1'b0, '0);
            sent++;
        end
        if (!end_on_byte)
        begin
            it.data_byte      = 8'($urandom_range(255));
            it.byte_present   = 1'b0;
            it.end_of_message = 1'b1;
            send_item(it, 1'b0, '0);
            sent++;
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t MISMATCH %s: got %h, expected %h", $realtime, what, got, want);
        error_count++;
    endtask

    // Receiver: random ready, or a held-off stretch when one is requested.
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                digest_ready <= 1'b0;
                hold_left--;
            end
            else
            begin
                digest_ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // Digest checker: each transfer against the oldest owed word.
    always @(posedge clk)
    begin
        sha1_pkg::out_item_t want;
        if (rst_n && digest_valid === 1'b1 && digest_ready)
        begin
            if (pending_digest_q.size() == 0)
            begin
                report_mismatch("digest word with none pending",
                                digest_out.digest_word, 32'h0);
            end
            else
            begin
                want = pending_digest_q.pop_front();
                if (digest_out.digest_word !== want.digest_word)
                begin
                    report_mismatch("digest_word", digest_out.digest_word,
                                    want.digest_word);
                end
                if (digest_out.digest_last !== want.digest_last)
                begin
                    report_mismatch("digest_last", 32'(digest_out.digest_last),
                                    32'(want.digest_last));
                end
            end
        end
    end

    // Watchdog: cycles in a row with no transfer on either side.
    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && item_ready === 1'b1) ||
            (digest_valid === 1'b1 && digest_ready))
        begin
            idle_count <= 0;
        end
        else
        begin
            idle_count <= idle_count + 1;
        end
    end

    initial
    begin
        wait (idle_count >= WATCHDOG_LIMIT);
        $display("%0t watchdog: no transfer for %0d cycles", $realtime, WATCHDOG_LIMIT);
        $display("sha1_message_digest_unit_tb: done, errors");
        $finish;
    end

    // Main sequence: reset, directed table, three random phases, drain.
    initial
    begin
        int p;
        int sent;
        int msgs;
        restart_hash();
        sched_words = '{default: '0};
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed messages: empty, "abc", a lone zero byte, byte extremes,
        // stray empty items, an end without a byte after data, and an empty
        // message right after a digest.
        dir_rows = '{
            '{'{8'h00, 1'b0, 1'b1}, 1'b1,
              160'hda39a3ee_5e6b4b0d_3255bfef_95601890_afd80709},
            '{'{8'h61, 1'b1, 1'b0}, 1'b0, 160'h0},
            '{'{8'hff, 1'b0, 1'b0}, 1'b0, 160'h0},
            '{'{8'h62, 1'b1, 1'b0}, 1'b0, 160'h0},
            '{'{8'h63, 1'b1, 1'b1}, 1'b1,
              160'ha9993e36_4706816a_ba3e2571_7850c26c_9cd0d89d},
            '{'{8'h00, 1'b1, 1'b1}, 1'b1,
              160'h5ba93c9d_b0cff93f_52b521d7_420e43f6_eda2784f},
            '{'{8'hff, 1'b1, 1'b0}, 1'b0, 160'h0},
            '{'{8'h00, 1'b1, 1'b0}, 1'b0, 160'h0},
            '{'{8'h00, 1'b0, 1'b0}, 1'b0, 160'h0},
            '{'{8'hff, 1'b1, 1'b0}, 1'b0, 160'h0},
            '{'{8'ha5, 1'b0, 1'b1}, 1'b0, 160'h0},
            '{'{8'hff, 1'b0, 1'b1}, 1'b1,
              160'hda39a3ee_5e6b4b0d_3255bfef_95601890_afd80709}
        };

        tx_idle_pct = 19;
        rx_idle_pct = 77;
        foreach (dir_rows[i])
        begin
            send_item(dir_rows[i].stim, dir_rows[i].typed, dir_rows[i].words);
        end

        for (p = 0; p < 3; p++)
        begin
            case (p)
                0:
                begin
                    tx_idle_pct = 19;
                    rx_idle_pct = 77;
                end
                1:
                begin
                    tx_idle_pct = 77;
                    rx_idle_pct = 19;
                end
                default:
                begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                    // Long output stall while items keep coming, so the
                    // block backs up and stops taking input.
                    hold_left = LONG_HOLD;
                end
            endcase
            sent = 0;
            msgs = 0;
            while (sent < PHASE_ITEMS || msgs < PHASE_MESSAGES)
            begin
                send_random_message(sent);
                msgs++;
            end
            // Sender goes quiet until every owed digest word has come back.
            @(negedge clk);
            item_valid <= 1'b0;
            while (pending_digest_q.size() != 0)
            begin
                @(posedge clk);
            end
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_digest_q.size() != 0)
        begin
            report_mismatch("digest words never returned",
                            32'(pending_digest_q.size()), 32'h0);
        end
        if (error_count == 0)
        begin
            $display("sha1_message_digest_unit_tb: done, clean");
        end
        else
        begin
            $display("sha1_message_digest_unit_tb: done, errors");
        end
        $finish;
    end

endmodule
